// ----- rtl/fbvt_pkg.sv -----
// shared types and constants for the frustum box visibility test unit
package fbvt_pkg;

	localparam int FracBitsDefault = 16;
	localparam int NumPlanes = 6;
	localparam int CoefW = 33;
	localparam int ValW = 32;
	localparam int AccW = 72;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_PLACE  = 2'd1;
	localparam logic [1:0] CMD_TEST   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic       load;
		logic       place;
		logic       xform;
		logic [1:0] axis;
		logic       sel_max;
		logic       mac_clr;
		logic       mac_en;
		logic [2:0] plane;
		logic [1:0] coef;
	} fbvt_cmd_t;

	typedef struct packed {
		logic neg;
	} fbvt_stat_t;

endpackage

// ----- rtl/fbvt_datapath.sv -----
// datapath: plane store, placement, box transform and shared multiply-accumulate
module fbvt_datapath #(
	parameter int FRAC_BITS = fbvt_pkg::FracBitsDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fbvt_pkg::fbvt_cmd_t           cmd,
	input  logic [1:0]                    column,
	input  logic signed [fbvt_pkg::ValW-1:0] value_0,
	input  logic signed [fbvt_pkg::ValW-1:0] value_1,
	input  logic signed [fbvt_pkg::ValW-1:0] value_2,
	input  logic signed [fbvt_pkg::ValW-1:0] value_3,
	input  logic signed [fbvt_pkg::ValW-1:0] value_4,
	input  logic signed [fbvt_pkg::ValW-1:0] value_5,
	output fbvt_pkg::fbvt_stat_t          stat
);
	import fbvt_pkg::*;

	logic signed [CoefW-1:0] plane_q [NumPlanes][4];
	logic signed [ValW-1:0]  pos_q [3];
	logic signed [ValW-1:0]  scl_q [3];
	logic signed [ValW-1:0]  bmin_q [3];
	logic signed [ValW-1:0]  bmax_q [3];
	logic signed [ValW-1:0]  tmin_q [3];
	logic signed [ValW-1:0]  tmax_q [3];
	logic signed [AccW-1:0]  acc_q;

	logic signed [ValW-1:0]   xb;
	logic signed [2*ValW-1:0] xprod;
	logic signed [2*ValW-1:0] xq;
	logic signed [2*ValW:0]   xsum;
	logic signed [ValW-1:0]   xsat;
	logic signed [CoefW-1:0]  ncoef;
	logic [1:0]               pax;
	logic signed [ValW-1:0]   pv;
	logic signed [CoefW+ValW-1:0] nprod;
	logic signed [AccW-1:0]   term;
	logic signed [AccW-1:0]   acc_nxt;
	logic signed [ValW-1:0]   r [3];

	assign r[0] = value_0;
	assign r[1] = value_1;
	assign r[2] = value_2;

	// box transform: floor(b*s / 2^F) + p, saturated
	always_comb begin
		xb    = cmd.sel_max ? bmax_q[cmd.axis] : bmin_q[cmd.axis];
		xprod = xb * scl_q[cmd.axis];
		xq    = xprod >>> FRAC_BITS;
		xsum  = {xq[2*ValW-1], xq} + (2*ValW+1)'(pos_q[cmd.axis]);
		if (xsum > (2*ValW+1)'(signed'({1'b0, {(ValW-1){1'b1}}})))
			xsat = {1'b0, {(ValW-1){1'b1}}};
		else if (xsum < -(2*ValW+1)'(signed'({1'b0, 1'b1, {(ValW-1){1'b0}}})))
			xsat = {1'b1, {(ValW-1){1'b0}}};
		else
			xsat = xsum[ValW-1:0];
	end

	// plane term: n * positive vertex, or d * 2^F
	always_comb begin
		ncoef = plane_q[cmd.plane][cmd.coef];
		pax   = (cmd.coef == 2'd3) ? 2'd0 : cmd.coef;
		pv    = ncoef[CoefW-1] ? tmin_q[pax] : tmax_q[pax];
		nprod = ncoef * pv;
		if (cmd.coef == 2'd3)
			term = AccW'(ncoef) <<< FRAC_BITS;
		else
			term = AccW'(nprod);
		acc_nxt = (cmd.mac_clr ? '0 : acc_q) + term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NumPlanes; p++)
				for (int c = 0; c < 4; c++)
					plane_q[p][c] <= '0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				scl_q[i] <= '0;
			end
		end else begin
			if (cmd.load) begin
				for (int k = 0; k < 3; k++) begin
					plane_q[2*k][column]   <= CoefW'(value_3) + CoefW'(r[k]);
					plane_q[2*k+1][column] <= CoefW'(value_3) - CoefW'(r[k]);
				end
			end
			if (cmd.place) begin
				pos_q[0] <= value_0;
				pos_q[1] <= value_1;
				pos_q[2] <= value_2;
				scl_q[0] <= value_3;
				scl_q[1] <= value_4;
				scl_q[2] <= value_5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.xform) begin
			if (cmd.sel_max)
				tmax_q[cmd.axis] <= xsat;
			else
				tmin_q[cmd.axis] <= xsat;
		end
		if (cmd.mac_en)
			acc_q <= acc_nxt;
	end

	// box corners captured when a test request is accepted
	always_ff @(posedge clk) begin
		if (cmd.mac_clr && !cmd.mac_en) begin
			bmin_q[0] <= value_0;
			bmin_q[1] <= value_1;
			bmin_q[2] <= value_2;
			bmax_q[0] <= value_3;
			bmax_q[1] <= value_4;
			bmax_q[2] <= value_5;
		end
	end

	assign stat.neg = acc_q[AccW-1];

endmodule

// ----- rtl/fbvt_ctrl.sv -----
// controller: sequences transform and plane accumulation per test request
module fbvt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          command,
	input  fbvt_pkg::fbvt_stat_t stat,
	output fbvt_pkg::fbvt_cmd_t cmd,
	output logic                busy,
	output logic                done,
	output logic                in_view
);
	import fbvt_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_XFORM, S_MAC, S_DONE} state_t;

	state_t     state_q;
	logic [2:0] step_q;
	logic [2:0] plane_q;
	logic [1:0] coef_q;
	logic       vis_q;
	logic       take;

	assign take = start && !busy;
	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.load    = take && (command == CMD_LOAD);
		cmd.place   = take && (command == CMD_PLACE);
		cmd.mac_clr = (take && (command == CMD_TEST)) || (state_q == S_MAC && coef_q == 2'd0);
		cmd.mac_en  = (state_q == S_MAC);
		cmd.xform   = (state_q == S_XFORM);
		cmd.axis    = 2'(step_q >> 1);
		cmd.sel_max = step_q[0];
		cmd.plane   = plane_q;
		cmd.coef    = coef_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			plane_q <= '0;
			coef_q  <= '0;
			vis_q   <= 1'b1;
			done    <= 1'b0;
			in_view <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take && command == CMD_TEST) begin
						state_q <= S_XFORM;
						step_q  <= '0;
					end
				end
				S_XFORM: begin
					if (step_q == 3'd5) begin
						step_q  <= '0;
						state_q <= S_MAC;
						plane_q <= '0;
						coef_q  <= '0;
						vis_q   <= 1'b1;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_MAC: begin
					if (coef_q == 2'd0 && plane_q != 3'd0 && stat.neg)
						vis_q <= 1'b0;
					coef_q <= coef_q + 2'd1;
					if (coef_q == 2'd3) begin
						if (plane_q == 3'(NumPlanes - 1))
							state_q <= S_DONE;
						else
							plane_q <= plane_q + 3'd1;
					end
				end
				S_DONE: begin
					in_view <= vis_q && !stat.neg;
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> done) else $error("done missing after finish");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == S_IDLE) else $error("done outside idle");
	a_plane_range: assert property (@(posedge clk) disable iff (!arst_n)
		plane_q < 3'(NumPlanes)) else $error("plane index out of range");
`endif

endmodule

// ----- rtl/frustum_box_visibility_test_unit.sv -----
// Frustum box visibility test unit. A load or placement request is stored when
// accepted and does not raise busy. A test request transforms the box corners
// through one shared multiplier, then runs one multiply-accumulate per plane
// coefficient, then gives in_view with done. busy stays high through the
// transform, accumulation and final step and falls as done rises; the receiver
// cannot stall, so in_view is valid only in the cycle that done is high.
module frustum_box_visibility_test_unit #(
	parameter int FRAC_BITS = fbvt_pkg::FracBitsDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    command,
	input  logic [1:0]                    column,
	input  logic signed [fbvt_pkg::ValW-1:0] value_0,
	input  logic signed [fbvt_pkg::ValW-1:0] value_1,
	input  logic signed [fbvt_pkg::ValW-1:0] value_2,
	input  logic signed [fbvt_pkg::ValW-1:0] value_3,
	input  logic signed [fbvt_pkg::ValW-1:0] value_4,
	input  logic signed [fbvt_pkg::ValW-1:0] value_5,
	output logic                          done,
	output logic                          in_view
);
	import fbvt_pkg::*;

	fbvt_cmd_t  cmd;
	fbvt_stat_t stat;

	fbvt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .command(command), .stat(stat),
		.cmd(cmd), .busy(busy), .done(done), .in_view(in_view)
	);

	fbvt_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .column(column),
		.value_0(value_0), .value_1(value_1), .value_2(value_2),
		.value_3(value_3), .value_4(value_4), .value_5(value_5), .stat(stat)
	);

endmodule

// ----- tb/frustum_box_visibility_test_unit_tb.sv -----
// testbench for the frustum box visibility test unit against a local predictor
`timescale 1ns / 100ps

module frustum_box_visibility_test_unit_tb;
	import fbvt_pkg::*;

	localparam int FB = FracBitsDefault;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] command;
	logic [1:0] column;
	logic signed [31:0] value_0, value_1, value_2, value_3, value_4, value_5;
	logic done;
	logic in_view;

	logic signed [32:0] plane_coef [NumPlanes][4];
	logic signed [31:0] obj_pos [3];
	logic signed [31:0] obj_scale [3];
	bit visibility_q[$];
	int fail_count;
	longint cycle_count;

	frustum_box_visibility_test_unit #(.FRAC_BITS(FB)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .column(column),
		.value_0(value_0), .value_1(value_1), .value_2(value_2),
		.value_3(value_3), .value_4(value_4), .value_5(value_5),
		.done(done), .in_view(in_view)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 1000000) begin
			$display("frustum_box_visibility_test_unit: mismatch");
			$finish;
		end
	end

	function automatic logic signed [31:0] place_corner(logic signed [31:0] b,
			logic signed [31:0] s, logic signed [31:0] p);
		logic signed [63:0] prod;
		logic signed [63:0] q;
		logic signed [63:0] t;
		prod = 64'(b) * 64'(s);
		q = prod >>> FB;
		t = q + 64'(p);
		if (t > 64'sd2147483647) t = 64'sd2147483647;
		if (t < -64'sd2147483648) t = -64'sd2147483648;
		return t[31:0];
	endfunction

	function automatic bit box_visible(logic signed [31:0] v [6]);
		logic signed [31:0] lo [3];
		logic signed [31:0] hi [3];
		logic signed [127:0] acc;
		logic signed [31:0] pv;
		for (int i = 0; i < 3; i++) begin
			lo[i] = place_corner(v[i], obj_scale[i], obj_pos[i]);
			hi[i] = place_corner(v[3 + i], obj_scale[i], obj_pos[i]);
		end
		for (int k = 0; k < NumPlanes; k++) begin
			acc = 128'(plane_coef[k][3]) <<< FB;
			for (int i = 0; i < 3; i++) begin
				pv = (plane_coef[k][i] >= 0) ? hi[i] : lo[i];
				acc += 128'(plane_coef[k][i]) * 128'(pv);
			end
			if (acc < 0) return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic send_request(logic [1:0] cmd, logic [1:0] col, logic signed [31:0] v [6]);
		@(negedge clk);
		while (busy) @(negedge clk);
		command <= cmd;
		column <= col;
		value_0 <= v[0]; value_1 <= v[1]; value_2 <= v[2];
		value_3 <= v[3]; value_4 <= v[4]; value_5 <= v[5];
		start <= 1'b1;
		@(posedge clk);
		case (cmd)
			CMD_LOAD: begin
				for (int k = 0; k < 3; k++) begin
					plane_coef[2 * k][col] = 33'(v[3]) + 33'(v[k]);
					plane_coef[2 * k + 1][col] = 33'(v[3]) - 33'(v[k]);
				end
			end
			CMD_PLACE: begin
				for (int i = 0; i < 3; i++) begin
					obj_pos[i] = v[i];
					obj_scale[i] = v[3 + i];
				end
			end
			CMD_TEST: visibility_q = {visibility_q, box_visible(v)};
			default: ;
		endcase
		@(negedge clk);
		start <= 1'b0;
		if ($urandom_range(0, 9) == 0) repeat ($urandom_range(5, 60)) @(negedge clk);
		else if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (visibility_q.size() == 0) begin
				$error("in_view: no request pending, actual %0b", in_view);
				fail_count++;
			end else begin
				bit e;
				e = visibility_q.pop_front();
				if (in_view !== e) begin
					$error("in_view: expected %0b actual %0b", e, in_view);
					fail_count++;
				end
			end
		end
	end

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sd0;
			3: return $signed(32'($urandom_range(0, 1 << 20)) - (32'd1 << 19));
			4: return $signed(32'($urandom_range(0, 1 << 24)) - (32'd1 << 23));
			default: return $signed(32'($urandom()));
		endcase
	endfunction

	task automatic random_values(output logic signed [31:0] v [6]);
		for (int i = 0; i < 6; i++) v[i] = rand_value();
	endtask

	task automatic load_view(bit wild);
		logic signed [31:0] v [6];
		for (int c = 0; c < 4; c++) begin
			if (wild) random_values(v);
			else for (int i = 0; i < 6; i++)
				v[i] = $signed(32'($urandom_range(0, 1 << 18)) - (32'd1 << 17));
			send_request(CMD_LOAD, 2'(c), v);
		end
	endtask

	task automatic test_directed();
		logic signed [31:0] v [6];
		v = '{default: 32'sd0};
		send_request(CMD_TEST, 2'd0, v);
		v = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
		send_request(CMD_TEST, 2'd0, v);
		v = '{32'sd0, 32'sd0, 32'sd0, -32'sd65536, 32'sd0, 32'sd0};
		send_request(CMD_LOAD, 2'd3, v);
		send_request(CMD_TEST, 2'd0, v);
		v = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000};
		send_request(CMD_LOAD, 2'd0, v);
		send_request(CMD_LOAD, 2'd1, v);
		send_request(CMD_LOAD, 2'd2, v);
		v = '{32'sh7fffffff, 32'sh80000000, 32'sd0,
			32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
		send_request(CMD_PLACE, 2'd3, v);
		v = '{32'sh80000000, 32'sh7fffffff, -32'sd1, 32'sh7fffffff, 32'sh80000000, 32'sd1};
		send_request(CMD_TEST, 2'd0, v);
		v = '{32'sd65536, 32'sd65536, 32'sd65536, -32'sd65536, -32'sd65536, -32'sd65536};
		send_request(CMD_TEST, 2'd0, v);
		random_values(v);
		send_request(CMD_UNUSED, 2'd2, v);
		send_request(CMD_TEST, 2'd1, v);
		load_view(1'b0);
		v = '{32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd65536, 32'sd65536};
		send_request(CMD_PLACE, 2'd0, v);
		v = '{-32'sd65536, -32'sd65536, -32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536};
		send_request(CMD_TEST, 2'd0, v);
	endtask

	task automatic test_random();
		logic signed [31:0] v [6];
		int sel;
		for (int n = 0; n < 400; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 5) load_view($urandom_range(0, 3) == 0);
			else if (sel < 15) begin
				random_values(v);
				if ($urandom_range(0, 1)) for (int i = 3; i < 6; i++)
					v[i] = $signed(32'($urandom_range(0, 1 << 18)) - (32'd1 << 17));
				send_request(CMD_PLACE, 2'($urandom()), v);
			end else if (sel < 18) begin
				random_values(v);
				send_request(CMD_UNUSED, 2'($urandom()), v);
			end else if (sel < 21) begin
				random_values(v);
				send_request(CMD_LOAD, 2'($urandom()), v);
			end else begin
				random_values(v);
				send_request(CMD_TEST, 2'($urandom()), v);
			end
		end
	endtask

	task automatic test_drain_pause();
		logic signed [31:0] v [6];
		while (visibility_q.size() != 0) @(negedge clk);
		random_values(v);
		send_request(CMD_TEST, 2'd0, v);
	endtask

	initial begin
		fail_count = 0;
		cycle_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_LOAD;
		column = 2'd0;
		{value_0, value_1, value_2, value_3, value_4, value_5} = '0;
		for (int k = 0; k < NumPlanes; k++) plane_coef[k] = '{default: '0};
		obj_pos = '{default: '0};
		obj_scale = '{default: '0};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_drain_pause();
		test_random();
		while (visibility_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (fail_count == 0) $display("frustum_box_visibility_test_unit: match");
		else $display("frustum_box_visibility_test_unit: mismatch");
		$finish;
	end

endmodule
